>>> src/owo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owo_pkg
// Shared widths, coefficient tables and types for the omni wheel odometry.
// ----------------------------------------------------------------------------
package owo_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int ACC_WIDTH   = 48;
    localparam int MPP_WIDTH   = 32;
    localparam int MAC_WIDTH   = 64;
    localparam int FRAC_SHIFT  = 14;
    localparam int COEF_BITS   = 15;

    localparam logic [MPP_WIDTH-1:0] MPP_RESET = MPP_WIDTH'(118474);
    localparam logic [MAC_WIDTH-1:0] ROUND_HALF = MAC_WIDTH'(1) << (FRAC_SHIFT - 1);

    // Q2.14 coefficient magnitudes and signs, rows x, y, heading.
    localparam logic [COEF_BITS-1:0] COEF_MAG [0:2][0:2] = '{
        '{COEF_BITS'(9460),  COEF_BITS'(9460),  COEF_BITS'(0)},
        '{COEF_BITS'(5461),  COEF_BITS'(5461),  COEF_BITS'(10923)},
        '{COEF_BITS'(32126), COEF_BITS'(32126), COEF_BITS'(32126)}
    };
    localparam logic COEF_NEG [0:2][0:2] = '{
        '{1'b0, 1'b1, 1'b0},
        '{1'b0, 1'b0, 1'b1},
        '{1'b0, 1'b0, 1'b0}
    };

    typedef struct packed {
        logic start;
        logic keep;
    } t_mac_cmd;

endpackage
`default_nettype wire

>>> src/owo_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owo_if
// Valid/ready channels for counts, pose results and the configuration write.
// ----------------------------------------------------------------------------
interface owo_count_if import owo_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] count_a;
    logic [COUNT_WIDTH-1:0] count_b;
    logic [COUNT_WIDTH-1:0] count_c;

    modport source (output valid, output count_a, output count_b, output count_c,
                    input ready);
    modport sink   (input valid, input count_a, input count_b, input count_c,
                    output ready);
endinterface

interface owo_pose_if import owo_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ACC_WIDTH-1:0] pose_x;
    logic [ACC_WIDTH-1:0] pose_y;
    logic [ACC_WIDTH-1:0] pose_heading;

    modport source (output valid, output pose_x, output pose_y, output pose_heading,
                    input ready);
    modport sink   (input valid, input pose_x, input pose_y, input pose_heading,
                    output ready);
endinterface

interface owo_cfg_if import owo_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [MPP_WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> src/owo_serial_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// owo_serial_mac
// Bit-serial shift-add multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module owo_serial_mac import owo_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_mac_cmd             i_cmd,
    input  wire logic [MAC_WIDTH-1:0] i_mcand,
    input  wire logic [MPP_WIDTH-1:0] i_mplier,
    input  wire logic [MAC_WIDTH-1:0] i_init,
    output logic                      o_busy,
    output logic [MAC_WIDTH-1:0]      o_acc
);

    logic                 r_busy;
    logic [MAC_WIDTH-1:0] r_mcand;
    logic [MPP_WIDTH-1:0] r_mplier;
    logic [MAC_WIDTH-1:0] r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= (i_mplier != '0);
        end else if (r_busy) begin
            r_busy <= ((r_mplier >> 1) != '0);
        end
    end

    // The product wraps modulo 2^64, as every intermediate does.
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mcand  <= i_mcand;
            r_mplier <= i_mplier;
            if (!i_cmd.keep) begin
                r_acc <= i_init;
            end
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= r_mcand << 1;
            r_mplier <= r_mplier >> 1;
        end
    end

    assign o_busy = r_busy;
    assign o_acc  = r_acc;

endmodule
`default_nettype wire

>>> src/omni_wheel_odometry.sv
`default_nettype none
// ----------------------------------------------------------------------------
// omni_wheel_odometry
// Three-wheel omni-drive odometry: encoder deltas, forward kinematics and
// wrapping pose accumulation, computed on one shared bit-serial multiplier.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Payload                              Accept
//  i_cfg     in    data: meters per pulse, Q0.32        valid && ready
//  i_count   in    count_a, count_b, count_c (32 b)     valid && ready
//  o_pose    out   pose_x, pose_y, pose_heading (48 b)  valid && ready
//
// One request is processed at a time. Its deltas are formed in the cycle it
// is accepted; then for each of the three pose rows the serial multiplier runs
// three coefficient products (issue, then wait while the multiplier steps
// through the significant bits of the coefficient magnitude) and one scaling
// product (stepping through the significant bits of meters_per_pulse), then
// one accumulate step. An item occupies the block from its accepting cycle
// through the publish step.
// Synchronous active-low reset clears the controller, the previous counts,
// the pose and loads meters_per_pulse with its reset value.
// A finished pose waits in the output register; the next request is accepted
// meanwhile and only stalls at its own publish step until o_pose is taken.
// ----------------------------------------------------------------------------
module omni_wheel_odometry import owo_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    owo_cfg_if.sink     i_cfg,
    owo_count_if.sink   i_count,
    owo_pose_if.source  o_pose
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_COEF_ISSUE,
        S_COEF_WAIT,
        S_SCALE_ISSUE,
        S_SCALE_WAIT,
        S_ACCUM,
        S_PUBLISH
    } t_state;

    t_state               r_state;
    logic [1:0]           r_row;
    logic [1:0]           r_k;
    logic [MPP_WIDTH-1:0] r_mpp;
    logic [COUNT_WIDTH-1:0] r_prev  [0:2];
    logic [COUNT_WIDTH-1:0] r_delta [0:2];
    logic [ACC_WIDTH-1:0]   r_pose  [0:2];
    logic                 r_out_valid;
    logic [ACC_WIDTH-1:0] r_out_x;
    logic [ACC_WIDTH-1:0] r_out_y;
    logic [ACC_WIDTH-1:0] r_out_h;

    logic                   count_fire;
    logic [COUNT_WIDTH-1:0] now [0:2];
    t_mac_cmd               mac_cmd;
    logic [MAC_WIDTH-1:0]   mac_mcand;
    logic [MAC_WIDTH-1:0]   mac_init;
    logic [MPP_WIDTH-1:0]   mac_mplier;
    logic                   mac_busy;
    logic [MAC_WIDTH-1:0]   mac_acc;
    logic [MAC_WIDTH-1:0]   delta_ext;
    logic signed [MAC_WIDTH-1:0] scaled;
    logic [ACC_WIDTH-1:0]   increment;

    assign i_cfg.ready   = 1'b1;
    assign i_count.ready = (r_state == S_IDLE);
    assign count_fire    = i_count.valid && i_count.ready;

    assign now[0] = i_count.count_a;
    assign now[1] = i_count.count_b;
    assign now[2] = i_count.count_c;

    // Coefficient products are formed as |C| times a possibly negated delta,
    // so for these products the multiplier sees a short unsigned operand.
    assign delta_ext = MAC_WIDTH'($signed(r_delta[r_k]));

    always_comb begin
        mac_cmd.start = (r_state == S_COEF_ISSUE) || (r_state == S_SCALE_ISSUE);
        mac_cmd.keep  = (r_state == S_COEF_ISSUE) && (r_k != 2'd0);
        if (r_state == S_SCALE_ISSUE) begin
            // The half-LSB rounding term seeds the scaling product.
            mac_mcand  = mac_acc;
            mac_mplier = r_mpp;
            mac_init   = ROUND_HALF;
        end else begin
            mac_mcand  = COEF_NEG[r_row][r_k] ? (MAC_WIDTH'(0) - delta_ext) : delta_ext;
            mac_mplier = MPP_WIDTH'(COEF_MAG[r_row][r_k]);
            mac_init   = '0;
        end
    end

    owo_serial_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (mac_cmd),
        .i_mcand  (mac_mcand),
        .i_mplier (mac_mplier),
        .i_init   (mac_init),
        .o_busy   (mac_busy),
        .o_acc    (mac_acc)
    );

    assign scaled    = $signed(mac_acc) >>> FRAC_SHIFT;
    assign increment = scaled[ACC_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpp <= MPP_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_mpp <= i_cfg.data;
        end
    end

    // Delta registers are pure payload and need no reset.
    always_ff @(posedge i_clk) begin
        if (count_fire) begin
            for (int k = 0; k < 3; k++) begin
                // A stored count of zero means the wheel has no history yet.
                r_delta[k] <= (r_prev[k] == '0) ? '0 : (now[k] - r_prev[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= 2'd0;
            r_k         <= 2'd0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_prev[k] <= '0;
                r_pose[k] <= '0;
            end
        end else begin
            if (o_pose.valid && o_pose.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (count_fire) begin
                        for (int k = 0; k < 3; k++) begin
                            r_prev[k] <= now[k];
                        end
                        r_row   <= 2'd0;
                        r_k     <= 2'd0;
                        r_state <= S_COEF_ISSUE;
                    end
                end
                S_COEF_ISSUE: begin
                    r_state <= S_COEF_WAIT;
                end
                S_COEF_WAIT: begin
                    if (!mac_busy) begin
                        if (r_k == 2'd2) begin
                            r_k     <= 2'd0;
                            r_state <= S_SCALE_ISSUE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_COEF_ISSUE;
                        end
                    end
                end
                S_SCALE_ISSUE: begin
                    r_state <= S_SCALE_WAIT;
                end
                S_SCALE_WAIT: begin
                    if (!mac_busy) begin
                        r_state <= S_ACCUM;
                    end
                end
                S_ACCUM: begin
                    r_pose[r_row] <= r_pose[r_row] + increment;
                    if (r_row == 2'd2) begin
                        r_state <= S_PUBLISH;
                    end else begin
                        r_row   <= r_row + 2'd1;
                        r_state <= S_COEF_ISSUE;
                    end
                end
                S_PUBLISH: begin
                    if (!r_out_valid || o_pose.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_x     <= r_pose[0];
                        r_out_y     <= r_pose[1];
                        r_out_h     <= r_pose[2];
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_pose.valid        = r_out_valid;
    assign o_pose.pose_x       = r_out_x;
    assign o_pose.pose_y       = r_out_y;
    assign o_pose.pose_heading = r_out_h;

endmodule
`default_nettype wire

>>> tb/sv/omni_wheel_odometry_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// omni_wheel_odometry_tb
// Self-checking bench for the three-wheel omni odometry. Count requests are
// driven on the valid/ready count channel. A local model of the encoder
// deltas, the Q2.14 kinematics and the wrapping Q16.32 pose keeps one
// expected pose for each accepted request. Each pose that leaves the block is
// compared field by field with the oldest expectation. Directed cases come
// first: unset wheels, count extremes, half-range jumps and scale extremes.
// Random phases follow, with sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module omni_wheel_odometry_tb;
    import owo_pkg::*;

    localparam int          RESET_CYCLES  = 12;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          END_CYCLES    = 300;
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          PHASE_ITEMS   = 420;

    // Kinematic matrix in Q2.14, rows x, y, heading; columns wheels 0..2.
    localparam longint KIN_COEF [3][3] = '{
        '{ 9460, -9460,      0},
        '{ 5461,  5461, -10923},
        '{32126, 32126,  32126}
    };

    typedef struct packed {
        bit [ACC_WIDTH-1:0] x;
        bit [ACC_WIDTH-1:0] y;
        bit [ACC_WIDTH-1:0] heading;
    } t_pose;

    logic clk;
    logic rst_n;

    owo_cfg_if   cfg_if ();
    owo_count_if count_if ();
    owo_pose_if  pose_if ();

    omni_wheel_odometry u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_count (count_if),
        .o_pose  (pose_if)
    );

    // Model state: scale register, last counts per wheel, pose accumulators.
    bit [MPP_WIDTH-1:0]   scale_model;
    bit [COUNT_WIDTH-1:0] last_count [3];
    bit [ACC_WIDTH-1:0]   pose_acc [3];

    t_pose       expected_poses [$];
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    function automatic void reset_odometry();
        scale_model = MPP_RESET;
        for (int k = 0; k < 3; k++) begin
            last_count[k] = '0;
            pose_acc[k]   = '0;
        end
    endfunction

    // Advances the model by one request and returns the pose it publishes.
    // A wheel whose last count is zero has no reference yet, so its delta is
    // zero; the new count is stored in every case.
    function automatic t_pose advance_odometry(input bit [COUNT_WIDTH-1:0] a,
                                               input bit [COUNT_WIDTH-1:0] b,
                                               input bit [COUNT_WIDTH-1:0] c);
        bit [COUNT_WIDTH-1:0] now [3];
        bit [COUNT_WIDTH-1:0] delta;
        longint               wheel_dist [3];
        longint               row_sum;
        t_pose                pose;
        now = '{a, b, c};
        for (int k = 0; k < 3; k++) begin
            delta = (last_count[k] == '0) ? '0 : now[k] - last_count[k];
            last_count[k] = now[k];
            wheel_dist[k] = longint'(signed'(delta)) * longint'({32'd0, scale_model});
        end
        for (int r = 0; r < 3; r++) begin
            row_sum = longint'(ROUND_HALF);
            for (int k = 0; k < 3; k++) begin
                row_sum += KIN_COEF[r][k] * wheel_dist[k];
            end
            pose_acc[r] += ACC_WIDTH'(row_sum >>> FRAC_SHIFT);
        end
        pose.x       = pose_acc[0];
        pose.y       = pose_acc[1];
        pose.heading = pose_acc[2];
        return pose;
    endfunction

    // Random count for one wheel, mostly a small move from its last count.
    function automatic bit [COUNT_WIDTH-1:0] pick_count(input bit [COUNT_WIDTH-1:0] last);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 68) begin
            return last + COUNT_WIDTH'($urandom_range(4000)) - COUNT_WIDTH'(2000);
        end else if (roll < 78) begin
            return $urandom;
        end else if (roll < 84) begin
            return '0;
        end else if (roll < 90) begin
            return (last ^ 32'h8000_0000) + COUNT_WIDTH'($urandom_range(6)) - COUNT_WIDTH'(3);
        end else if (roll < 95) begin
            case ($urandom_range(3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'hFFFF_FFFF;
                default: return 32'h0000_0001;
            endcase
        end
        return last;
    endfunction

    // Sends one count request. Valid stays high after acceptance so that a
    // following request without a gap needs no second assignment in one step.
    task automatic send_counts(input bit [COUNT_WIDTH-1:0] a,
                               input bit [COUNT_WIDTH-1:0] b,
                               input bit [COUNT_WIDTH-1:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            count_if.valid <= 1'b0;
            @(posedge clk);
        end
        count_if.valid   <= 1'b1;
        count_if.count_a <= a;
        count_if.count_b <= b;
        count_if.count_c <= c;
        @(posedge clk);
        while (count_if.ready !== 1'b1) @(posedge clk);
        expected_poses.push_back(advance_odometry(a, b, c));
    endtask

    // Holds the sender off until every expected pose has come out.
    task automatic wait_for_poses();
        count_if.valid <= 1'b0;
        while (expected_poses.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_scale(input bit [MPP_WIDTH-1:0] value);
        wait_for_poses();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge clk);
        while (cfg_if.ready !== 1'b1) @(posedge clk);
        scale_model = value;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_field(input string field, input bit [ACC_WIDTH-1:0] want,
                               input logic [ACC_WIDTH-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("pose %s mismatch: expected %h, got %h", field, want, got);
            end
        end
    endtask

    // Receiver: ready is redrawn every cycle from the current stall rate.
    always @(posedge clk) begin
        pose_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin : pose_checker
        t_pose want;
        if (rst_n === 1'b1 && pose_if.valid === 1'b1 && pose_if.ready === 1'b1) begin
            if (expected_poses.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("unexpected pose: x %h y %h heading %h",
                             pose_if.pose_x, pose_if.pose_y, pose_if.pose_heading);
                end
            end else begin
                want = expected_poses.pop_front();
                check_field("x", want.x, pose_if.pose_x);
                check_field("y", want.y, pose_if.pose_y);
                check_field("heading", want.heading, pose_if.pose_heading);
            end
        end
    end

    // Wheels with no stored count contribute nothing, also after a zero count.
    task automatic test_unset_counts();
        send_counts(32'd100, -32'sd200, 32'd300);
        send_counts(32'd150, -32'sd250, 32'd400);
        send_counts(32'd0, 32'd0, 32'd0);
        send_counts(32'd55, 32'd66, 32'd77);
    endtask

    task automatic test_count_extremes();
        send_counts(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        send_counts(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
        send_counts(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    endtask

    // A jump of half the count range reads as a move the other way.
    task automatic test_half_range_jumps();
        send_counts(32'd1, 32'd1, 32'd1);
        send_counts(32'h8000_0001, 32'h8000_0000, 32'h8000_0002);
    endtask

    // Full-scale distances make the pose wrap at the accumulator width; zero and unit scales follow.
    task automatic test_scale_extremes();
        write_scale(32'hFFFF_FFFF);
        send_counts(32'h0000_0001, 32'h8000_0001, 32'h4000_0000);
        send_counts(32'h7FFF_FFFF, 32'h0000_0002, 32'hC000_0000);
        send_counts(32'h0000_0001, 32'h8000_0001, 32'h4000_0000);
        write_scale(32'd0);
        send_counts(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F);
        send_counts(32'h0000_0003, 32'h0000_0004, 32'h0000_0005);
        write_scale(32'd1);
        send_counts(32'h0000_0400, 32'hFFFF_FC00, 32'h8000_0000);
        send_counts(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0001);
    endtask

    task automatic test_random_traffic(input int unsigned idle_pct,
                                       input int unsigned stall_pct,
                                       input bit [MPP_WIDTH-1:0] scale);
        write_scale(scale);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(149) == 0) begin
                wait_for_poses();
            end
            send_counts(pick_count(last_count[0]), pick_count(last_count[1]),
                        pick_count(last_count[2]));
        end
        wait_for_poses();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        reset_odometry();
        rst_n            <= 1'b0;
        cfg_if.valid     <= 1'b0;
        cfg_if.data      <= '0;
        count_if.valid   <= 1'b0;
        count_if.count_a <= '0;
        count_if.count_b <= '0;
        count_if.count_c <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_unset_counts();
        test_count_extremes();
        test_half_range_jumps();
        test_scale_extremes();
        test_random_traffic(0, 0, MPP_RESET);
        test_random_traffic(45, 0, $urandom);
        test_random_traffic(0, 45, MPP_WIDTH'($urandom_range(1, 1 << 20)));
        test_random_traffic(11, 11, 32'hFFFF_FFFF);

        wait_for_poses();
        repeat (END_CYCLES) @(posedge clk);
        if (expected_poses.size() != 0) begin
            mismatches += expected_poses.size();
            $display("%0d expected poses never arrived", expected_poses.size());
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
